// File: src/wmf_pkg.sv
// Shared types, register indexes and command/status structs of the window filter.
package wmf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 7;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_WINDOW_SIZE  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_FILTER_MODE  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_DISC_SHAPE   = 3'd4;

  localparam logic [1:0] MODE_MEAN = 2'd0;
  localparam logic [1:0] MODE_MAX  = 2'd1;
  localparam logic [1:0] MODE_MIN  = 2'd2;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       flush;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_last;
  } pix_out_t;

  typedef struct packed {
    logic load;
    logic store;
    logic cen_rd;
    logic scan;
    logic div_init;
    logic div_step;
    logic emit;
  } wmf_cmd_t;

  typedef struct packed {
    logic no_result;
    logic scan_last;
    logic div_done;
    logic out_free;
  } wmf_stat_t;

endpackage

// File: src/window_mean_min_max_filter_top.sv
// Top level of the windowed mean / maximum / minimum RGBA filter.
// Usage: pixels enter in raster order on in_valid/in_ready with in_data; one
// output transaction per frame pixel leaves on out_valid/out_ready with out_data.
// Configuration writes (cfg_valid, cfg_index, cfg_data) are always taken and
// must only be issued while the block is idle. The result for pixel p appears
// on the input transaction at position p + R*W + R (R window radius, W width),
// so R*W + R flush transactions drain the end of a frame.
// An item that yields no result is only stored; one that yields a result is
// then processed by the window walk of one line-store read per cycle plus a
// bit-serial divider for the mean, of 16 steps at the default parameters.
// The output register holds a result while the receiver stalls; the next
// item is accepted meanwhile and waits at its emit step until the slot frees.
// Reset (rst_n low, synchronous) clears positions and loads default
// configuration; line-store contents are not cleared and need no clearing pass.
module window_mean_min_max_filter_top import wmf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pix_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pix_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  wmf_cmd_t  cmd;
  wmf_stat_t stat;

  assign cfg_ready = 1'b1;

  wmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wmf_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // emit only into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free) else $error("emit into occupied output slot");

  // emitted result is presented next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid) else $error("emitted result not presented");

  // one datapath step at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.store, cmd.cen_rd, cmd.scan, cmd.div_init, cmd.div_step, cmd.emit}))
    else $error("overlapping datapath commands");

  // accepted transaction is stored next cycle
  a_load_store: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.store) else $error("accepted transaction not stored");

endmodule

// File: src/wmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/wmf_ctrl.sv
// Controller state machine sequencing store, window scan, divide and emit.
module wmf_ctrl import wmf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  wmf_stat_t stat,
  output wmf_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_STORE, ST_CENTRE, ST_SCAN, ST_DRAIN, ST_DIVINIT, ST_DIVIDE, ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_STORE;
      ST_STORE:   state_nxt = stat.no_result ? ST_IDLE : ST_CENTRE;
      ST_CENTRE:  state_nxt = ST_SCAN;
      ST_SCAN:    if (stat.scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN:   state_nxt = ST_DIVINIT;
      ST_DIVINIT: state_nxt = ST_DIVIDE;
      ST_DIVIDE:  if (stat.div_done) state_nxt = ST_EMIT;
      ST_EMIT:    if (stat.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // decode commands
  assign in_ready     = (state_r == ST_IDLE);
  assign cmd.load     = in_ready && in_valid;
  assign cmd.store    = (state_r == ST_STORE);
  assign cmd.cen_rd   = (state_r == ST_CENTRE);
  assign cmd.scan     = (state_r == ST_SCAN);
  assign cmd.div_init = (state_r == ST_DIVINIT);
  assign cmd.div_step = (state_r == ST_DIVIDE);
  assign cmd.emit     = (state_r == ST_EMIT) && stat.out_free;

endmodule

// File: src/wmf_dp.sv
// Datapath: config registers, line store, window walk, accumulators, dividers, output.
module wmf_dp import wmf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  pix_in_t           in_data,
  input  wmf_cmd_t          cmd,
  output wmf_stat_t         stat,
  input  logic              out_ready,
  output logic              out_valid,
  output pix_out_t          out_data
);

  localparam int RW      = $clog2(MAX_RADIUS + 1);
  localparam int DW      = RW + 1;
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int CMPW    = (WW > 11) ? WW : 11;
  localparam int LAG_MAX = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
  localparam int AW      = $clog2(2 * LAG_MAX + 1);
  localparam int DEPTH   = 1 << AW;
  localparam int TAPS    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CW      = $clog2(TAPS + 1);
  localparam int SW      = CW + 8;
  localparam int KW      = $clog2(SW);
  localparam int FW      = WW + 16;
  localparam int LW      = WW + RW + 1;
  localparam int NYW     = 18;
  localparam int NXW     = XW + 2;

  // configuration registers
  logic [10:0] cfg_width_r;
  logic [15:0] cfg_height_r;
  logic [3:0]  cfg_size_r;
  logic [1:0]  cfg_mode_r;
  logic        cfg_disc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= 11'd1024;
      cfg_height_r <= 16'd1;
      cfg_size_r   <= 4'd3;
      cfg_mode_r   <= MODE_MEAN;
      cfg_disc_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data[10:0];
        CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_data;
        CFG_WINDOW_SIZE:  cfg_size_r   <= cfg_data[3:0];
        CFG_FILTER_MODE:  cfg_mode_r   <= cfg_data[1:0];
        CFG_DISC_SHAPE:   cfg_disc_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp geometry
  logic [CMPW-1:0] w_ext;
  logic [WW-1:0]   w_eff;
  logic [15:0]     h_eff;
  logic [3:0]      half4, rad4;
  logic [RW-1:0]   rad;
  logic signed [DW-1:0] rad_s;

  assign w_ext = CMPW'(cfg_width_r);
  assign w_eff = (cfg_width_r == 11'd0) ? WW'(1) :
                 (w_ext > CMPW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_ext[WW-1:0];
  assign h_eff = (cfg_height_r == 16'd0) ? 16'd1 : cfg_height_r;
  assign half4 = {1'b0, cfg_size_r[3:1]};
  assign rad4  = (half4 > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : half4;
  assign rad   = rad4[RW-1:0];
  assign rad_s = $signed({1'b0, rad});

  // register frame size and lag products
  logic [FW-1:0] frame_r;
  logic [LW-1:0] lag_r;

  always_ff @(posedge clk) begin
    frame_r <= FW'(w_eff) * FW'(h_eff);
    lag_r   <= LW'(LW'(rad) * LW'(w_eff) + LW'(rad));
  end

  // line store
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic [31:0]   pos_r;
  pix_in_t       pix_r;
  logic [AW-1:0] scan_addr_r, cen_addr_r;

  assign wr_en   = cmd.store && (pos_r < 32'(frame_r));
  assign rd_addr = cmd.cen_rd ? cen_addr_r : scan_addr_r;

  wmf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos_r[AW-1:0]),
    .wr_data ({pix_r.alpha_in, pix_r.blue_in, pix_r.green_in, pix_r.red_in}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // window walk
  logic [15:0]           row_r;
  logic [XW-1:0]         col_r;
  logic signed [DW-1:0]  dy_r, dx_r;
  logic signed [NYW-1:0] ny_r, ny0;
  logic signed [NXW-1:0] nx_r, nx0;
  logic [DW-1:0]         adx_f, ady_f;
  logic [RW-1:0]         adx, ady;
  logic [11:0]           dist4, size_sq;
  logic                  tap_ok, disc_ok, tv_r, cen_q_r;
  logic [AW-1:0]         row_step;

  assign ny0      = $signed({2'b00, row_r}) - $signed(NYW'(rad));
  assign nx0      = $signed({2'b00, col_r}) - $signed(NXW'(rad));
  assign adx_f    = dx_r[DW-1] ? -dx_r : dx_r;
  assign ady_f    = dy_r[DW-1] ? -dy_r : dy_r;
  assign adx      = adx_f[RW-1:0];
  assign ady      = ady_f[RW-1:0];
  assign dist4    = (12'(adx) * 12'(adx) + 12'(ady) * 12'(ady)) << 2;
  assign size_sq  = 12'(cfg_size_r) * 12'(cfg_size_r);
  assign disc_ok  = !cfg_disc_r || (dist4 < size_sq);
  assign tap_ok   = !ny_r[NYW-1] && (ny_r[NYW-2:0] < (NYW-1)'(h_eff)) &&
                    !nx_r[NXW-1] && (nx_r[NXW-2:0] < (NXW-1)'(w_eff));
  assign row_step = AW'(w_eff) - AW'({rad, 1'b0});

  assign stat.no_result = pos_r < 32'(lag_r);
  assign stat.scan_last = (dx_r == rad_s) && (dy_r == rad_s);

  // accumulators and dividers
  logic [SW-1:0] acc_r [3];
  logic [SW-1:0] dq_r  [3];
  logic [CW-1:0] rem_r [3];
  logic [CW-1:0] cnt_r;
  logic [KW-1:0] div_k_r;
  logic [CW:0]   trial [3];
  logic [7:0]    alpha_r;
  logic          centre_in, last;

  assign stat.div_done = (div_k_r == KW'(SW - 1));

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem_r[c], dq_r[c][SW-1]};
    end
  end

  assign centre_in = (row_r < h_eff) && (WW'(col_r) < w_eff);
  assign last      = (17'(row_r) + 17'd1 >= 17'(h_eff)) &&
                     ((XW+1)'(col_r) + (XW+1)'(1) >= (XW+1)'(w_eff));

  // item sequencing: store, walk, accumulate, divide
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r <= in_data;
    end
    if (cmd.store) begin
      dy_r        <= -rad_s;
      dx_r        <= -rad_s;
      ny_r        <= ny0;
      nx_r        <= nx0;
      scan_addr_r <= pos_r[AW-1:0] - AW'({lag_r, 1'b0});
      cen_addr_r  <= pos_r[AW-1:0] - AW'(lag_r);
      cnt_r       <= '0;
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= (cfg_mode_r == MODE_MIN) ? SW'(255) : '0;
      end
    end else if (tv_r) begin
      cnt_r <= cnt_r + CW'(1);
      for (int c = 0; c < 3; c++) begin
        unique case (cfg_mode_r)
          MODE_MEAN: acc_r[c] <= acc_r[c] + SW'(rd_data[8*c +: 8]);
          MODE_MAX:  if (SW'(rd_data[8*c +: 8]) > acc_r[c]) acc_r[c] <= SW'(rd_data[8*c +: 8]);
          MODE_MIN:  if (SW'(rd_data[8*c +: 8]) < acc_r[c]) acc_r[c] <= SW'(rd_data[8*c +: 8]);
          default: ;
        endcase
      end
    end
    if (cmd.scan) begin
      if (dx_r == rad_s) begin
        dx_r        <= -rad_s;
        nx_r        <= nx0;
        dy_r        <= dy_r + DW'(1);
        ny_r        <= ny_r + NYW'(1);
        scan_addr_r <= scan_addr_r + row_step;
      end else begin
        dx_r        <= dx_r + DW'(1);
        nx_r        <= nx_r + NXW'(1);
        scan_addr_r <= scan_addr_r + AW'(1);
      end
    end
    if (cen_q_r) begin
      alpha_r <= centre_in ? rd_data[31:24] : 8'd0;
    end
    if (cmd.div_init) begin
      div_k_r <= '0;
      for (int c = 0; c < 3; c++) begin
        dq_r[c]  <= acc_r[c] + SW'(cnt_r >> 1);
        rem_r[c] <= '0;
      end
    end else if (cmd.div_step) begin
      div_k_r <= div_k_r + KW'(1);
      for (int c = 0; c < 3; c++) begin
        if (trial[c] >= {1'b0, cnt_r}) begin
          rem_r[c] <= CW'(trial[c] - {1'b0, cnt_r});
          dq_r[c]  <= {dq_r[c][SW-2:0], 1'b1};
        end else begin
          rem_r[c] <= trial[c][CW-1:0];
          dq_r[c]  <= {dq_r[c][SW-2:0], 1'b0};
        end
      end
    end
  end

  // tap and centre read flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r    <= 1'b0;
      cen_q_r <= 1'b0;
    end else begin
      tv_r    <= cmd.scan && tap_ok && disc_ok;
      cen_q_r <= cmd.cen_rd;
    end
  end

  // pick channel result
  logic [7:0] res [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      unique case (cfg_mode_r)
        MODE_MEAN: res[c] = (cnt_r == '0) ? 8'd0 : dq_r[c][7:0];
        MODE_MAX:  res[c] = acc_r[c][7:0];
        MODE_MIN:  res[c] = acc_r[c][7:0];
        default:   res[c] = 8'd0;
      endcase
    end
  end

  // positions and output register
  logic out_valid_r;
  pix_out_t out_r;

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.store && (pos_r != 32'hFFFF_FFFF)) begin
        pos_r <= pos_r + 32'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (last) begin
          pos_r <= '0;
          row_r <= '0;
          col_r <= '0;
        end else if ((XW+1)'(col_r) + (XW+1)'(1) >= (XW+1)'(w_eff)) begin
          col_r <= '0;
          row_r <= row_r + 16'd1;
        end else begin
          col_r <= col_r + XW'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.red_out    <= res[0];
      out_r.green_out  <= res[1];
      out_r.blue_out   <= res[2];
      out_r.alpha_out  <= alpha_r;
      out_r.frame_last <= last;
    end
  end

endmodule
